FILE: rtl/core/dgll_pkg.sv
// shared types, widths and mode codes for the diagonal gaussian log-likelihood unit
// no dependencies
package dgll_pkg;

  // default model dimensions
  localparam int unsigned MAX_STATES_DEF   = 64;
  localparam int unsigned MAX_MIXTURES_DEF = 8;
  localparam int unsigned MAX_DIM_DEF      = 64;

  // field widths
  localparam int unsigned MODE_W     = 2;
  localparam int unsigned STATE_W    = 6;
  localparam int unsigned MIX_W      = 3;
  localparam int unsigned DIM_W      = 6;
  localparam int unsigned SAMPLE_W   = 16;
  localparam int unsigned INV_W      = 16;
  localparam int unsigned LOGC_W     = 32;
  localparam int unsigned SCORE_W    = 32;
  localparam int unsigned FDIM_W     = 7;
  localparam int unsigned IN_TDATA_W = 80;

  // datapath widths
  localparam int unsigned SQ_W   = 32;
  localparam int unsigned PROD_W = 48;
  localparam int unsigned TERM_W = 40;
  localparam int unsigned ACC_W  = 48;
  localparam int unsigned DIFF_SHIFT = 8;

  typedef enum logic [MODE_W-1:0] {
    MODE_LOAD_MODEL = 2'd0,
    MODE_LOAD_LOGC  = 2'd1,
    MODE_SCORE      = 2'd2
  } mode_e;

  // per-element frame position
  typedef struct packed {
    logic first;
    logic last;
  } elem_ctl_t;

  // memory access request for one accepted transfer
  typedef struct packed {
    logic model_we;
    logic logc_we;
    logic rd_en;
  } mem_req_t;

endpackage

FILE: rtl/core/dgll_param_mem.sv
// model parameter memories: mean/inverse variance per entry, log constant per component
// depends on dgll_pkg
module dgll_param_mem #(
  parameter int unsigned ENTRY_N = 32768,
  parameter int unsigned COMP_N  = 512,
  localparam int unsigned ENTRY_AW = (ENTRY_N > 1) ? $clog2(ENTRY_N) : 1,
  localparam int unsigned COMP_AW  = (COMP_N > 1) ? $clog2(COMP_N) : 1
) (
  input  logic                            clk_i,
  input  dgll_pkg::mem_req_t              req_i,
  input  logic [ENTRY_AW-1:0]             entry_addr_i,
  input  logic [COMP_AW-1:0]              comp_addr_i,
  input  logic [dgll_pkg::SAMPLE_W-1:0]   mean_i,
  input  logic [dgll_pkg::INV_W-1:0]      inv_i,
  input  logic [dgll_pkg::LOGC_W-1:0]     logc_i,
  output logic [dgll_pkg::SAMPLE_W-1:0]   mean_o,
  output logic [dgll_pkg::INV_W-1:0]      inv_o,
  output logic [dgll_pkg::LOGC_W-1:0]     logc_o
);

  localparam int unsigned MODEL_W = dgll_pkg::SAMPLE_W + dgll_pkg::INV_W;

  logic [MODEL_W-1:0]          model_mem [ENTRY_N];
  logic [dgll_pkg::LOGC_W-1:0] logc_mem  [COMP_N];
  logic [MODEL_W-1:0]          model_rd_q;
  logic [dgll_pkg::LOGC_W-1:0] logc_rd_q;

  // single port each: a transfer either writes or reads
  always_ff @(posedge clk_i) begin
    if (req_i.model_we) begin
      model_mem[entry_addr_i] <= {inv_i, mean_i};
    end else if (req_i.rd_en) begin
      model_rd_q <= model_mem[entry_addr_i];
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.logc_we) begin
      logc_mem[comp_addr_i] <= logc_i;
    end else if (req_i.rd_en) begin
      logc_rd_q <= logc_mem[comp_addr_i];
    end
  end

  assign mean_o = model_rd_q[dgll_pkg::SAMPLE_W-1:0];
  assign inv_o  = model_rd_q[MODEL_W-1:dgll_pkg::SAMPLE_W];
  assign logc_o = logc_rd_q;

endmodule

FILE: rtl/core/dgll_score_pipe.sv
// scoring pipeline: difference, square, weight, accumulate, clip, output register
// depends on dgll_pkg; stage 1 data comes from dgll_param_mem read registers
module dgll_score_pipe (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            issue_valid_i,
  input  dgll_pkg::elem_ctl_t             issue_ctl_i,
  input  logic [dgll_pkg::SAMPLE_W-1:0]   issue_sample_i,
  input  logic [dgll_pkg::SAMPLE_W-1:0]   mean_i,
  input  logic [dgll_pkg::INV_W-1:0]      inv_i,
  input  logic [dgll_pkg::LOGC_W-1:0]     logc_i,
  output logic                            ready_o,
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output logic [dgll_pkg::SCORE_W-1:0]    out_score_o,
  output logic                            out_sat_o
);

  localparam int unsigned SC_W = dgll_pkg::ACC_W + 1;
  localparam int unsigned DIFF_SHIFT_L = dgll_pkg::DIFF_SHIFT;

  // stage 1: element and memory read data
  logic                            v1_q;
  dgll_pkg::elem_ctl_t             ctl1_q;
  logic [dgll_pkg::SAMPLE_W-1:0]   x1_q;
  // stage 2: squared difference
  logic                            v2_q;
  dgll_pkg::elem_ctl_t             ctl2_q;
  logic [dgll_pkg::SQ_W-1:0]       sq2_q;
  logic [dgll_pkg::INV_W-1:0]      inv2_q;
  logic [dgll_pkg::LOGC_W-1:0]     logc2_q;
  // stage 3: weighted term
  logic                            v3_q;
  dgll_pkg::elem_ctl_t             ctl3_q;
  logic [dgll_pkg::TERM_W-1:0]     term3_q;
  logic [dgll_pkg::LOGC_W-1:0]     logc3_q;
  // running sum and stage 4 frame sum
  logic [dgll_pkg::ACC_W-1:0]      acc_q;
  logic                            v4_q;
  logic [dgll_pkg::ACC_W-1:0]      acc4_q;
  logic [dgll_pkg::LOGC_W-1:0]     logc4_q;
  // output register
  logic                            out_valid_q;
  logic [dgll_pkg::SCORE_W-1:0]    score_q;
  logic                            sat_q;

  logic take1, take2, take3, take4, take5;

  logic signed [dgll_pkg::SAMPLE_W:0] diff;
  logic        [dgll_pkg::SAMPLE_W:0] diff_abs;
  logic        [dgll_pkg::SAMPLE_W-1:0] mag;
  logic        [dgll_pkg::SQ_W-1:0]   sq;
  logic        [dgll_pkg::PROD_W-1:0] prod;
  logic        [dgll_pkg::ACC_W-1:0]  acc_base;
  logic        [dgll_pkg::ACC_W:0]    acc_sum;
  logic        [dgll_pkg::ACC_W-1:0]  acc_new;
  logic signed [SC_W-1:0]             sc;
  logic                               sc_low, sc_high;

  // stage advance chain, driven back from the output register
  assign take5 = !out_valid_q || out_ready_i;
  assign take4 = !v4_q || take5;
  assign take3 = !v3_q || !ctl3_q.last || take4;
  assign take2 = !v2_q || take3;
  assign take1 = !v1_q || take2;
  assign ready_o = take1;

  // |x - mean| fits 16 bits
  assign diff     = $signed({x1_q[dgll_pkg::SAMPLE_W-1], x1_q})
                  - $signed({mean_i[dgll_pkg::SAMPLE_W-1], mean_i});
  assign diff_abs = diff[dgll_pkg::SAMPLE_W] ? (dgll_pkg::SAMPLE_W+1)'(-diff)
                                             : (dgll_pkg::SAMPLE_W+1)'(diff);
  assign mag      = diff_abs[dgll_pkg::SAMPLE_W-1:0];
  assign sq       = dgll_pkg::SQ_W'(mag) * dgll_pkg::SQ_W'(mag);

  assign prod = dgll_pkg::PROD_W'(sq2_q) * dgll_pkg::PROD_W'(inv2_q);

  // accumulate with saturation at the top of the 48-bit range
  assign acc_base = ctl3_q.first ? '0 : acc_q;
  assign acc_sum  = {1'b0, acc_base} + (dgll_pkg::ACC_W+1)'(term3_q);
  assign acc_new  = acc_sum[dgll_pkg::ACC_W] ? '1 : acc_sum[dgll_pkg::ACC_W-1:0];

  // logc - sum/2, clipped to 32 bits
  assign sc = $signed({{(SC_W-dgll_pkg::LOGC_W){logc4_q[dgll_pkg::LOGC_W-1]}}, logc4_q})
            - $signed({2'b00, acc4_q[dgll_pkg::ACC_W-1:1]});
  assign sc_low  = sc[SC_W-1] && !(&sc[SC_W-2:dgll_pkg::SCORE_W-1]);
  assign sc_high = !sc[SC_W-1] && (|sc[SC_W-2:dgll_pkg::SCORE_W-1]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q        <= 1'b0;
      v2_q        <= 1'b0;
      v3_q        <= 1'b0;
      v4_q        <= 1'b0;
      out_valid_q <= 1'b0;
      acc_q       <= '0;
    end else begin
      if (take1) begin
        v1_q <= issue_valid_i;
      end
      if (take2) begin
        v2_q <= v1_q;
      end
      if (take3) begin
        v3_q <= v2_q;
      end
      if (v3_q && take3) begin
        acc_q <= acc_new;
      end
      if (take4) begin
        v4_q <= v3_q && ctl3_q.last;
      end
      if (take5) begin
        out_valid_q <= v4_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (take1 && issue_valid_i) begin
      ctl1_q <= issue_ctl_i;
      x1_q   <= issue_sample_i;
    end
    if (take2 && v1_q) begin
      ctl2_q  <= ctl1_q;
      sq2_q   <= sq;
      inv2_q  <= inv_i;
      logc2_q <= logc_i;
    end
    if (take3 && v2_q) begin
      ctl3_q  <= ctl2_q;
      term3_q <= prod[dgll_pkg::PROD_W-1:DIFF_SHIFT_L];
      logc3_q <= logc2_q;
    end
    if (take4 && v3_q && ctl3_q.last) begin
      acc4_q  <= acc_new;
      logc4_q <= logc3_q;
    end
    if (take5 && v4_q) begin
      sat_q <= sc_low || sc_high;
      if (sc_low) begin
        score_q <= {1'b1, {(dgll_pkg::SCORE_W-1){1'b0}}};
      end else if (sc_high) begin
        score_q <= {1'b0, {(dgll_pkg::SCORE_W-1){1'b1}}};
      end else begin
        score_q <= sc[dgll_pkg::SCORE_W-1:0];
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_score_o = score_q;
  assign out_sat_o   = sat_q;

endmodule

FILE: rtl/core/diagonal_gaussian_log_likelihood_unit.sv
// top level of the diagonal-covariance gaussian log-likelihood scorer
// depends on dgll_pkg, dgll_param_mem, dgll_score_pipe
// throughput: one transfer per cycle (loads and score elements alike) while the output drains
// pipeline: a frame score reaches m_axis after its last element's transfer has passed through
//   the memory read, square, weight, accumulate and clip registers
// reset: rst_ni low clears pipeline valids, the running sum and sets dims in use to 64
//   (or MAX_DIM if smaller); parameter memories are not cleared and must be loaded first
module diagonal_gaussian_log_likelihood_unit #(
  parameter int unsigned MAX_STATES   = dgll_pkg::MAX_STATES_DEF,
  parameter int unsigned MAX_MIXTURES = dgll_pkg::MAX_MIXTURES_DEF,
  parameter int unsigned MAX_DIM      = dgll_pkg::MAX_DIM_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  // configuration write: feature_dim
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [dgll_pkg::FDIM_W-1:0]       cfg_wdata_i,
  // input stream
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  // state_index, mixture_index, dim_index, sample_value, inv_variance, log_constant, zero pad
  input  logic [dgll_pkg::IN_TDATA_W-1:0]   s_axis_tdata,
  // mode
  input  logic [dgll_pkg::MODE_W-1:0]       s_axis_tuser,
  // result stream
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  // score
  output logic [dgll_pkg::SCORE_W-1:0]      m_axis_tdata,
  // saturated
  output logic [0:0]                        m_axis_tuser
);

  localparam int unsigned COMP_N   = MAX_STATES * MAX_MIXTURES;
  localparam int unsigned ENTRY_N  = COMP_N * MAX_DIM;
  localparam int unsigned COMP_AW  = (COMP_N > 1) ? $clog2(COMP_N) : 1;
  localparam int unsigned ENTRY_AW = (ENTRY_N > 1) ? $clog2(ENTRY_N) : 1;
  localparam int unsigned LAST_W   = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
  localparam int unsigned LAST_RST = ((MAX_DIM < 64) ? MAX_DIM : 64) - 1;

  // tdata field offsets, lowest first
  localparam int unsigned ST_LO  = 0;
  localparam int unsigned MX_LO  = ST_LO + dgll_pkg::STATE_W;
  localparam int unsigned DM_LO  = MX_LO + dgll_pkg::MIX_W;
  localparam int unsigned SMP_LO = DM_LO + dgll_pkg::DIM_W;
  localparam int unsigned INV_LO = SMP_LO + dgll_pkg::SAMPLE_W;
  localparam int unsigned LC_LO  = INV_LO + dgll_pkg::INV_W;

  logic [dgll_pkg::STATE_W-1:0]  st;
  logic [dgll_pkg::MIX_W-1:0]    mx;
  logic [dgll_pkg::DIM_W-1:0]    dm;
  logic [dgll_pkg::SAMPLE_W-1:0] sample;
  logic [dgll_pkg::INV_W-1:0]    inv;
  logic [dgll_pkg::LOGC_W-1:0]   logc;
  dgll_pkg::mode_e               mode;

  logic [LAST_W-1:0]   last_dim_q, last_dim_d;
  logic [31:0]         comp_wide, entry_wide;
  logic [COMP_AW-1:0]  comp_addr;
  logic [ENTRY_AW-1:0] entry_addr;
  logic                comp_ok, dim_ok, dim_in_use, accept, pipe_ready;
  dgll_pkg::mem_req_t  mem_req;
  dgll_pkg::elem_ctl_t elem_ctl;

  logic [dgll_pkg::SAMPLE_W-1:0] rd_mean;
  logic [dgll_pkg::INV_W-1:0]    rd_inv;
  logic [dgll_pkg::LOGC_W-1:0]   rd_logc;

  // field unpacking
  assign st     = s_axis_tdata[ST_LO +: dgll_pkg::STATE_W];
  assign mx     = s_axis_tdata[MX_LO +: dgll_pkg::MIX_W];
  assign dm     = s_axis_tdata[DM_LO +: dgll_pkg::DIM_W];
  assign sample = s_axis_tdata[SMP_LO +: dgll_pkg::SAMPLE_W];
  assign inv    = s_axis_tdata[INV_LO +: dgll_pkg::INV_W];
  assign logc   = s_axis_tdata[LC_LO +: dgll_pkg::LOGC_W];
  assign mode   = dgll_pkg::mode_e'(s_axis_tuser);

  // configuration: keep the last dimension index in use, clamped to 1..MAX_DIM dims
  assign cfg_ready_o = 1'b1;

  always_comb begin
    if (cfg_wdata_i == '0) begin
      last_dim_d = '0;
    end else if (32'(cfg_wdata_i) > 32'(MAX_DIM)) begin
      last_dim_d = LAST_W'(MAX_DIM - 1);
    end else begin
      last_dim_d = LAST_W'(32'(cfg_wdata_i) - 32'd1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_dim_q <= LAST_W'(LAST_RST);
    end else if (cfg_valid_i && cfg_ready_o) begin
      last_dim_q <= last_dim_d;
    end
  end

  // address generation: component = state * mixtures + mixture, entry adds the dimension
  assign comp_wide  = 32'(st) * 32'(MAX_MIXTURES) + 32'(mx);
  assign comp_addr  = comp_wide[COMP_AW-1:0];
  assign entry_wide = 32'(comp_addr) * 32'(MAX_DIM) + 32'(dm);
  assign entry_addr = entry_wide[ENTRY_AW-1:0];

  // out-of-range addresses are dropped silently
  assign comp_ok    = (32'(st) < 32'(MAX_STATES)) && (32'(mx) < 32'(MAX_MIXTURES));
  assign dim_ok     = 32'(dm) < 32'(MAX_DIM);
  assign dim_in_use = 32'(dm) <= 32'(last_dim_q);

  // every transfer waits only for room in the scoring pipeline
  assign s_axis_tready = pipe_ready;
  assign accept        = s_axis_tvalid && s_axis_tready;

  always_comb begin
    mem_req = '0;
    unique case (mode)
      dgll_pkg::MODE_LOAD_MODEL: mem_req.model_we = accept && comp_ok && dim_ok;
      dgll_pkg::MODE_LOAD_LOGC:  mem_req.logc_we  = accept && comp_ok;
      dgll_pkg::MODE_SCORE:      mem_req.rd_en    = accept && comp_ok && dim_in_use;
      default:                   mem_req          = '0;
    endcase
  end

  // dimension zero restarts the sum; the last dimension in use closes the frame
  assign elem_ctl.first = (dm == '0);
  assign elem_ctl.last  = (32'(dm) == 32'(last_dim_q));

  dgll_param_mem #(
    .ENTRY_N (ENTRY_N),
    .COMP_N  (COMP_N)
  ) u_mem (
    .clk_i        (clk_i),
    .req_i        (mem_req),
    .entry_addr_i (entry_addr),
    .comp_addr_i  (comp_addr),
    .mean_i       (sample),
    .inv_i        (inv),
    .logc_i       (logc),
    .mean_o       (rd_mean),
    .inv_o        (rd_inv),
    .logc_o       (rd_logc)
  );

  dgll_score_pipe u_pipe (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .issue_valid_i  (mem_req.rd_en),
    .issue_ctl_i    (elem_ctl),
    .issue_sample_i (sample),
    .mean_i         (rd_mean),
    .inv_i          (rd_inv),
    .logc_i         (rd_logc),
    .ready_o        (pipe_ready),
    .out_valid_o    (m_axis_tvalid),
    .out_ready_i    (m_axis_tready),
    .out_score_o    (m_axis_tdata),
    .out_sat_o      (m_axis_tuser[0])
  );

endmodule

FILE: rtl/core/dgll_checker.sv
// port-level checks for diagonal_gaussian_log_likelihood_unit, bound to the top level
// depends on dgll_pkg
module dgll_checker (
  input logic                              clk_i,
  input logic                              rst_ni,
  input logic                              s_axis_tready,
  input logic                              m_axis_tvalid,
  input logic                              m_axis_tready,
  input logic [dgll_pkg::SCORE_W-1:0]      m_axis_tdata,
  input logic [0:0]                        m_axis_tuser
);

  // stalled result holds until transferred
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
    else $error("stalled result changed");

  // the sum only lowers the score, so clipping happens only at the negative limit
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser[0] |->
      m_axis_tdata == {1'b1, {(dgll_pkg::SCORE_W-1){1'b0}}})
    else $error("saturated score not at negative limit");

  // no result can be pending right out of reset
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(rst_ni) |-> !m_axis_tvalid)
    else $error("result valid right after reset");

  // the pipeline keeps room whenever no result is waiting at the output
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !m_axis_tvalid |-> s_axis_tready)
    else $error("input stalled with empty output");

endmodule

bind diagonal_gaussian_log_likelihood_unit dgll_checker u_dgll_checker (.*);

FILE: bench/tb.sv
`timescale 1ns / 100ps
// self-checking testbench for diagonal_gaussian_log_likelihood_unit: loads model words, streams
// frames and compares every frame score against an in-bench fixed-point scorer
// depends on dgll_pkg and the unit's rtl
module tb;

  typedef longint unsigned u64_t;

  localparam int unsigned MODE_W     = dgll_pkg::MODE_W;
  localparam int unsigned STATE_W    = dgll_pkg::STATE_W;
  localparam int unsigned MIX_W      = dgll_pkg::MIX_W;
  localparam int unsigned DIM_W      = dgll_pkg::DIM_W;
  localparam int unsigned SAMPLE_W   = dgll_pkg::SAMPLE_W;
  localparam int unsigned INV_W      = dgll_pkg::INV_W;
  localparam int unsigned LOGC_W     = dgll_pkg::LOGC_W;
  localparam int unsigned SCORE_W    = dgll_pkg::SCORE_W;
  localparam int unsigned FDIM_W     = dgll_pkg::FDIM_W;
  localparam int unsigned ACC_W      = dgll_pkg::ACC_W;
  localparam int unsigned IN_TDATA_W = dgll_pkg::IN_TDATA_W;
  localparam int unsigned MAX_DIM_N  = dgll_pkg::MAX_DIM_DEF;
  localparam int unsigned MAX_ST_N   = dgll_pkg::MAX_STATES_DEF;
  localparam int unsigned MAX_MX_N   = dgll_pkg::MAX_MIXTURES_DEF;

  localparam int unsigned PIPE_LAT      = 4;
  localparam int unsigned SETTLE_CYCLES = PIPE_LAT + 6;
  localparam int unsigned CYCLE_LIMIT   = 600000;
  localparam int unsigned HOLD_CYCLES   = 300;
  localparam int unsigned N_READY       = 8;
  localparam int unsigned IDLE_PCT      = 29;
  localparam int unsigned ENTRIES       = MAX_ST_N * MAX_MX_N * MAX_DIM_N;
  localparam int unsigned COMPS         = MAX_ST_N * MAX_MX_N;
  localparam logic [MODE_W-1:0] MODE_RESERVED = 2'd3;
  localparam u64_t   SUM_CEIL  = (u64_t'(1) << ACC_W) - 1;
  localparam longint SCORE_MIN = -(longint'(1) <<< (SCORE_W - 1));
  localparam longint SCORE_MAX = (longint'(1) <<< (SCORE_W - 1)) - 1;

  typedef struct {
    logic [MODE_W-1:0]          mode;
    logic [STATE_W-1:0]         state_idx;
    logic [MIX_W-1:0]           mix_idx;
    logic [DIM_W-1:0]           dim_idx;
    logic signed [SAMPLE_W-1:0] sample;
    logic [INV_W-1:0]           inv_var;
    logic signed [LOGC_W-1:0]   logc;
  } gauss_item_t;

  typedef struct {
    logic [SCORE_W-1:0] score;
    logic               sat;
  } frame_score_t;

  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  cfg_valid_i = 1'b0;
  logic                  cfg_ready_o;
  logic [FDIM_W-1:0]     cfg_wdata_i = '0;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [IN_TDATA_W-1:0] s_axis_tdata = '0;
  logic [MODE_W-1:0]     s_axis_tuser = '0;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [SCORE_W-1:0]    m_axis_tdata;
  logic [0:0]            m_axis_tuser;

  // scorer state mirrored in the bench
  logic [SAMPLE_W-1:0] mean_mem [0:ENTRIES-1];
  logic [INV_W-1:0]    inv_mem  [0:ENTRIES-1];
  logic [LOGC_W-1:0]   logc_mem [0:COMPS-1];
  logic [ACC_W-1:0]    run_sum = '0;
  logic [FDIM_W-1:0]   fdim = 7'd64;
  frame_score_t        score_q [$];

  // components whose every dimension and log constant have been loaded
  logic [STATE_W-1:0] ready_st [N_READY];
  logic [MIX_W-1:0]   ready_mx [N_READY];

  int unsigned errors = 0;
  int unsigned cycle_count = 0;
  int unsigned stall_left = 0;
  int unsigned hold_reqs = 0;
  int unsigned hold_taken = 0;
  logic        idle_en = 1'b1;
  logic        offering = 1'b0;

  diagonal_gaussian_log_likelihood_unit DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_wdata_i   (cfg_wdata_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  always #10 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // result side: a requested hold-off is counted down here, otherwise random stalls
  always @(posedge clk_i) begin
    if (hold_reqs != hold_taken) begin
      stall_left = HOLD_CYCLES;
      hold_taken = hold_reqs;
    end
    if (stall_left != 0) begin
      m_axis_tready <= 1'b0;
      stall_left = stall_left - 1;
    end else begin
      m_axis_tready <= !(idle_en && ($urandom_range(99) < IDLE_PCT));
    end
  end

  task automatic report_mismatch(input string msg);
    $display("mismatch at cycle %0d: %s", cycle_count, msg);
    errors++;
  endtask

  always @(posedge clk_i) begin : result_check
    frame_score_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (score_q.size() == 0) begin
        report_mismatch($sformatf("unexpected score %h", m_axis_tdata));
      end else begin
        want = score_q.pop_front();
        if (m_axis_tdata !== want.score)
          report_mismatch($sformatf("score %h, want %h", m_axis_tdata, want.score));
        if (m_axis_tuser[0] !== want.sat)
          report_mismatch($sformatf("saturated %b, want %b", m_axis_tuser[0], want.sat));
      end
    end
  end

  function automatic int unsigned dims_used();
    if (fdim == 0) return 1;
    if (fdim > MAX_DIM_N) return MAX_DIM_N;
    return 32'(fdim);
  endfunction

  // fixed-point scorer: updates the mirrored stores and queues a frame score on the last dim
  task automatic predict_item(input gauss_item_t it);
    logic [STATE_W+MIX_W-1:0]       comp;
    logic [STATE_W+MIX_W+DIM_W-1:0] entry;
    longint       sd, mag, lc, total;
    u64_t         term, sum;
    int unsigned  nd;
    frame_score_t r;
    comp  = {it.state_idx, it.mix_idx};
    entry = {it.state_idx, it.mix_idx, it.dim_idx};
    nd    = dims_used();
    if (it.mode == dgll_pkg::MODE_LOAD_LOGC) begin
      logc_mem[comp] = it.logc;
    end else if (it.mode == dgll_pkg::MODE_LOAD_MODEL) begin
      mean_mem[entry] = it.sample;
      inv_mem[entry]  = it.inv_var;
    end else if (it.mode == dgll_pkg::MODE_SCORE && it.dim_idx < nd) begin
      sd   = longint'($signed(it.sample)) - longint'($signed(mean_mem[entry]));
      mag  = (sd < 0) ? -sd : sd;
      term = (u64_t'(mag) * u64_t'(mag) * u64_t'(inv_mem[entry])) >> dgll_pkg::DIFF_SHIFT;
      if (it.dim_idx == 0) begin
        sum = 0;
      end else begin
        sum = u64_t'(run_sum);
      end
      sum = sum + term;
      if (sum > SUM_CEIL) sum = SUM_CEIL;
      run_sum = sum[ACC_W-1:0];
      if (it.dim_idx == nd - 1) begin
        lc    = longint'($signed(logc_mem[comp]));
        total = lc - longint'(sum >> 1);
        r.sat = 1'b0;
        if (total < SCORE_MIN) begin
          total = SCORE_MIN;
          r.sat = 1'b1;
        end else if (total > SCORE_MAX) begin
          total = SCORE_MAX;
          r.sat = 1'b1;
        end
        r.score = total[SCORE_W-1:0];
        score_q = {score_q, r};
      end
    end
  endtask

  function automatic gauss_item_t mk_item(input logic [MODE_W-1:0] mode,
                                          input logic [STATE_W-1:0] st,
                                          input logic [MIX_W-1:0] mx,
                                          input logic [DIM_W-1:0] dm,
                                          input logic [SAMPLE_W-1:0] sample,
                                          input logic [INV_W-1:0] inv_var,
                                          input logic [LOGC_W-1:0] logc);
    gauss_item_t it;
    it.mode      = mode;
    it.state_idx = st;
    it.mix_idx   = mx;
    it.dim_idx   = dm;
    it.sample    = sample;
    it.inv_var   = inv_var;
    it.logc      = logc;
    return it;
  endfunction

  // score element on a loaded component; unused fields carry noise
  function automatic gauss_item_t mk_score(input int unsigned k, input logic [DIM_W-1:0] dm,
                                           input logic [SAMPLE_W-1:0] x);
    return mk_item(dgll_pkg::MODE_SCORE, ready_st[k], ready_mx[k], dm, x,
                   INV_W'($urandom), LOGC_W'($urandom));
  endfunction

  // mostly a sample close to the stored mean so scores stay in range, sometimes anything
  function automatic logic [SAMPLE_W-1:0] near_mean(input int unsigned k,
                                                     input logic [DIM_W-1:0] dm);
    logic [SAMPLE_W-1:0] mu;
    mu = mean_mem[{ready_st[k], ready_mx[k], dm}];
    if ($urandom_range(4) == 0) return SAMPLE_W'($urandom);
    return mu + SAMPLE_W'($urandom_range(0, 255)) - 16'd128;
  endfunction

  function automatic logic [INV_W-1:0] random_inv();
    int unsigned r;
    r = $urandom_range(7);
    if (r == 0) return '0;
    if (r < 3) return INV_W'($urandom);
    return INV_W'($urandom_range(1, 31));
  endfunction

  // one transfer on the input stream; valid stays up when no gap follows
  task automatic send_item(input gauss_item_t it);
    int unsigned gap;
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= it.mode;
    s_axis_tdata  <= {1'b0, it.logc, it.inv_var, it.sample, it.dim_idx, it.mix_idx,
                      it.state_idx};
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    predict_item(it);
    offering = 1'b1;
    if (idle_en && ($urandom_range(99) < IDLE_PCT)) begin
      gap = $urandom_range(1, 4);
      s_axis_tvalid <= 1'b0;
      offering = 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  task automatic wait_drained();
    if (offering) begin
      s_axis_tvalid <= 1'b0;
      offering = 1'b0;
    end
    while (score_q.size() != 0) @(posedge clk_i);
    // ignored or non-final elements may still be in flight
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic set_feature_dim(input logic [FDIM_W-1:0] value);
    wait_drained();
    cfg_valid_i <= 1'b1;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    fdim = value;
    cfg_valid_i <= 1'b0;
  endtask

  // load every dimension and the log constant of a handful of components
  task automatic test_model_load();
    int unsigned k, d;
    logic [SAMPLE_W-1:0] mu;
    logic [INV_W-1:0]    iv;
    logic [LOGC_W-1:0]   lc;
    ready_st[0] = '0;  ready_mx[0] = '0;
    ready_st[1] = '1;  ready_mx[1] = '1;
    ready_st[2] = 6'd42; ready_mx[2] = 3'd5;
    ready_st[3] = 6'd21; ready_mx[3] = 3'd2;
    for (k = 4; k < N_READY; k++) begin
      ready_st[k] = STATE_W'($urandom_range(1, MAX_ST_N - 2));
      ready_mx[k] = MIX_W'($urandom_range(0, MAX_MX_N - 1));
    end
    for (k = 0; k < N_READY; k++) begin
      for (d = 0; d < MAX_DIM_N; d++) begin
        case (k)
          0: begin
            mu = 16'h7FFF;
            iv = 16'hFFFF;
          end
          1: begin
            mu = 16'h8000;
            iv = 16'hFFFF;
          end
          2: begin
            mu = '0;
            iv = '0;
          end
          default: begin
            mu = SAMPLE_W'($urandom);
            iv = random_inv();
          end
        endcase
        send_item(mk_item(dgll_pkg::MODE_LOAD_MODEL, ready_st[k], ready_mx[k], DIM_W'(d),
                          mu, iv, LOGC_W'($urandom)));
      end
      case (k)
        0:       lc = 32'h7FFF_FFFF;
        1:       lc = 32'h8000_0000;
        2:       lc = '0;
        default: lc = LOGC_W'($urandom);
      endcase
      send_item(mk_item(dgll_pkg::MODE_LOAD_LOGC, ready_st[k], ready_mx[k], DIM_W'($urandom),
                        SAMPLE_W'($urandom), INV_W'($urandom), lc));
    end
  endtask

  task automatic test_directed_cases();
    int unsigned d;
    set_feature_dim(7'd1);
    // single-dimension frames: largest distances clip low, zero weight gives the constant
    send_item(mk_score(0, 6'd0, 16'h8000));
    send_item(mk_score(1, 6'd0, 16'h7FFF));
    send_item(mk_score(2, 6'd0, 16'h0000));
    send_item(mk_score(3, 6'd0, mean_mem[{ready_st[3], ready_mx[3], 6'd0}]));
    // element past the dimensions in use is dropped
    send_item(mk_score(3, 6'd63, SAMPLE_W'($urandom)));
    // reserved mode is dropped whatever the fields
    send_item(mk_item(MODE_RESERVED, '1, '1, '1, '1, '1, '1));
    send_item(mk_item(MODE_RESERVED, '0, '0, '0, '0, '0, '0));
    // zero dims behaves as one
    set_feature_dim(7'd0);
    send_item(mk_score(4, 6'd0, near_mean(4, 6'd0)));
    send_item(mk_score(4, 6'd1, near_mean(4, 6'd1)));
    // oversized count clamps to the maximum; no dimension zero, so the sum carries on
    set_feature_dim(7'd127);
    send_item(mk_score(5, 6'd63, near_mean(5, 6'd63)));
    set_feature_dim(7'd64);
    send_item(mk_score(2, 6'd63, SAMPLE_W'($urandom)));
    set_feature_dim(7'd3);
    for (d = 0; d < 3; d++) send_item(mk_score(6, DIM_W'(d), near_mean(6, DIM_W'(d))));
    for (d = 1; d < 3; d++) send_item(mk_score(6, DIM_W'(d), near_mean(6, DIM_W'(d))));
  endtask

  // largest terms without dimension zero drive the running sum into its ceiling
  task automatic test_accum_saturation();
    set_feature_dim(7'd2);
    send_item(mk_score(1, 6'd0, 16'h7FFF));
    repeat (260) send_item(mk_score(1, 6'd1, 16'h7FFF));
  endtask

  // result side holds off while frames keep coming, so the input must stall
  task automatic test_backpressure();
    int unsigned k;
    set_feature_dim(7'd1);
    hold_reqs++;
    repeat (60) begin
      k = $urandom_range(0, N_READY - 1);
      send_item(mk_score(k, 6'd0, near_mean(k, 6'd0)));
    end
    wait_drained();
  endtask

  // mostly complete frames with random content, plus reloads, truncated frames and noise
  task automatic run_random_phase(input int unsigned n);
    int unsigned counted, nd, pick, k, first, stop, d;
    nd = dims_used();
    counted = 0;
    while (counted < n) begin
      pick = $urandom_range(99);
      k = $urandom_range(0, N_READY - 1);
      if (pick < 72) begin
        first = 0;
        if (nd > 1 && $urandom_range(9) == 0) first = $urandom_range(1, nd - 1);
        stop = nd;
        if ($urandom_range(9) == 0) stop = $urandom_range(first + 1, nd);
        for (d = first; d < stop; d++)
          send_item(mk_score(k, DIM_W'(d), near_mean(k, DIM_W'(d))));
        counted += stop - first;
      end else if (pick < 82) begin
        if ($urandom_range(1) == 0)
          send_item(mk_item(dgll_pkg::MODE_LOAD_MODEL, ready_st[k], ready_mx[k],
                            DIM_W'($urandom), SAMPLE_W'($urandom), random_inv(),
                            LOGC_W'($urandom)));
        else
          send_item(mk_item(dgll_pkg::MODE_LOAD_MODEL, STATE_W'($urandom), MIX_W'($urandom),
                            DIM_W'($urandom), SAMPLE_W'($urandom), random_inv(),
                            LOGC_W'($urandom)));
        counted++;
      end else if (pick < 88) begin
        if ($urandom_range(1) == 0)
          send_item(mk_item(dgll_pkg::MODE_LOAD_LOGC, ready_st[k], ready_mx[k],
                            DIM_W'($urandom), SAMPLE_W'($urandom), INV_W'($urandom),
                            LOGC_W'($urandom)));
        else
          send_item(mk_item(dgll_pkg::MODE_LOAD_LOGC, STATE_W'($urandom), MIX_W'($urandom),
                            DIM_W'($urandom), SAMPLE_W'($urandom), INV_W'($urandom),
                            LOGC_W'($urandom)));
        counted++;
      end else if (pick < 93) begin
        send_item(mk_item(MODE_RESERVED, STATE_W'($urandom), MIX_W'($urandom),
                          DIM_W'($urandom), SAMPLE_W'($urandom), INV_W'($urandom),
                          LOGC_W'($urandom)));
      end else if (nd < MAX_DIM_N) begin
        send_item(mk_score(k, DIM_W'($urandom_range(nd, MAX_DIM_N - 1)), SAMPLE_W'($urandom)));
      end else begin
        send_item(mk_score(k, DIM_W'($urandom), SAMPLE_W'($urandom)));
        counted++;
      end
    end
  endtask

  // both sides at full rate for a long stretch
  task automatic test_full_rate();
    idle_en = 1'b0;
    set_feature_dim(FDIM_W'($urandom_range(4, 12)));
    run_random_phase(250);
    wait_drained();
    idle_en = 1'b1;
  endtask

  task automatic test_random();
    int unsigned i;
    logic [FDIM_W-1:0] fd;
    for (i = 0; i < 8; i++) begin
      case (i)
        0:       fd = 7'd64;
        1:       fd = 7'd1;
        2:       fd = 7'd127;
        3:       fd = 7'd0;
        4:       fd = 7'd65;
        5:       fd = 7'd2;
        default: fd = FDIM_W'($urandom_range(3, 63));
      endcase
      set_feature_dim(fd);
      run_random_phase(85);
    end
  endtask

  initial begin
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_model_load();
    test_directed_cases();
    test_accum_saturation();
    test_backpressure();
    test_full_rate();
    test_random();
    wait_drained();
    if (errors == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
